// ===== sv/fws_pkg.sv =====
// shared types, constants and state encodings of the filtered waving sketch
package fws_pkg;

  localparam int FROWS      = 3;
  localparam int FCOLS      = 1024;
  localparam int FIDX_W     = $clog2(FCOLS);
  localparam int IDX_FIELD_W = 10;
  localparam int CNT_W      = 8;
  localparam int THR_W      = 8;
  localparam int TOT_W      = 12;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam int ROWS       = 1024;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int SLOTS      = 8;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W      = 64;
  localparam int COUNT_BITS = 32;
  localparam int ST_W       = 3;
  localparam int WAV_W      = 32;
  localparam int SUM_W      = WAV_W + 2;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(15);
  localparam logic [TOT_W-1:0] LIM_RESET = TOT_W'(1536);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = CFG_IDX_W'(1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // status bits of a record entry
  localparam int ST_VALID = 0;
  localparam int ST_EXACT = 1;
  localparam int ST_SIGN  = 2;

  typedef struct packed {
    logic                   req_type;
    logic [KEY_W-1:0]       flow_key;
    logic [IDX_FIELD_W-1:0] filter_index_a;
    logic [IDX_FIELD_W-1:0] filter_index_b;
    logic [IDX_FIELD_W-1:0] filter_index_c;
    logic [IDX_FIELD_W-1:0] record_row;
    logic                   flow_sign;
  } req_t;

  typedef struct packed {
    logic                  passed_filter;
    logic                  found;
    logic [COUNT_BITS-1:0] flow_count;
  } rsp_t;

  typedef struct packed {
    logic                         start;
    logic [FROWS-1:0][FIDX_W-1:0] idx;
  } filt_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic pass;
  } filt_stat_t;

  typedef struct packed {
    logic             start;
    logic             query;
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] row;
    logic             sign;
  } rec_cmd_t;

  typedef struct packed {
    logic                  ready;
    logic                  done;
    logic                  found;
    logic [COUNT_BITS-1:0] count;
  } rec_stat_t;

  typedef enum logic [2:0] {
    F_CLEAR, F_IDLE, F_UPD, F_SWEEP_RD, F_SWEEP_WR
  } filt_state_e;

  typedef enum logic [1:0] {R_CLEAR, R_IDLE, R_SCAN, R_WRITE} rec_state_e;

  typedef enum logic [1:0] {T_IDLE, T_FILT, T_REC, T_OUT} top_state_e;

  typedef enum logic [1:0] {HIT_MATCH, HIT_EMPTY, HIT_FULL, HIT_NONE} slot_hit_e;

endpackage

// ===== sv/filtered_waving_sketch_core.sv =====
// top level: request sequencer, configuration registers and result register
// After reset the block clears its filter and record memories before it takes
// a request. A query goes straight to the record table, where the scan unit
// compares one record slot at a time; an insert first updates the filter, and
// one that fails the filter ends without a record step. An insert that brings
// the reached total to the limit also sweeps the filter over all its columns.
// A result that waits for out_ready_i holds back the next result, not the
// next request.
module filtered_waving_sketch_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fws_pkg::req_t                  in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fws_pkg::rsp_t                  out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [fws_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fws_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import fws_pkg::*;

  top_state_e state_q, state_d;
  logic [THR_W-1:0] thr_q;
  logic [TOT_W-1:0] lim_q;
  req_t req_q;
  logic pass_q, pass_d, found_q, found_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d, load;
  rsp_t out_q;
  logic accept;

  filt_cmd_t  fcmd;
  filt_stat_t fstat;
  rec_cmd_t   rcmd;
  rec_stat_t  rstat;

  assign in_ready_o = (state_q == T_IDLE) && fstat.ready && rstat.ready;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      lim_q <= LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_LIMIT:     lim_q <= cfg_wdata_i[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fcmd.start  = accept && (in_req_i.req_type == REQ_INSERT);
    fcmd.idx[0] = in_req_i.filter_index_a[FIDX_W-1:0];
    fcmd.idx[1] = in_req_i.filter_index_b[FIDX_W-1:0];
    fcmd.idx[2] = in_req_i.filter_index_c[FIDX_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    pass_d = pass_q;
    found_d = found_q;
    count_d = count_q;
    load = 1'b0;
    rcmd.start = 1'b0;
    rcmd.query = req_q.req_type;
    rcmd.key = req_q.flow_key;
    rcmd.row = req_q.record_row[ROW_W-1:0];
    rcmd.sign = req_q.flow_sign;
    unique case (state_q)
      T_IDLE: begin
        rcmd.query = in_req_i.req_type;
        rcmd.key = in_req_i.flow_key;
        rcmd.row = in_req_i.record_row[ROW_W-1:0];
        rcmd.sign = in_req_i.flow_sign;
        if (accept) begin
          pass_d = 1'b0;
          found_d = 1'b0;
          count_d = '0;
          if (in_req_i.req_type == REQ_QUERY) begin
            rcmd.start = 1'b1;
            state_d = T_REC;
          end else begin
            state_d = T_FILT;
          end
        end
      end
      T_FILT: begin
        if (fstat.done) begin
          pass_d = fstat.pass;
          if (fstat.pass) begin
            rcmd.start = 1'b1;
            state_d = T_REC;
          end else begin
            state_d = T_OUT;
          end
        end
      end
      T_REC: begin
        if (rstat.done) begin
          found_d = rstat.found;
          count_d = rstat.count;
          state_d = T_OUT;
        end
      end
      T_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load = 1'b1;
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      out_valid_q <= 1'b0;
      pass_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      pass_q <= pass_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    if (accept) req_q <= in_req_i;
    if (load) begin
      out_q.passed_filter <= pass_q;
      out_q.found <= found_q;
      out_q.flow_count <= count_q;
    end
  end

  fws_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fcmd),
    .threshold_i (thr_q),
    .limit_i     (lim_q),
    .stat_o      (fstat)
  );

  fws_record u_record (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rcmd),
    .stat_o (rstat)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("ready while a request is in flight");
  a_filt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.done |-> state_q == T_FILT) else $error("filter done out of sequence");
  a_rec_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rstat.done |-> state_q == T_REC) else $error("record done out of sequence");
  a_found_not_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> !out_rsp_o.passed_filter)
    else $error("result both found and passed");

endmodule

// ===== sv/fws_filter.sv =====
// three-row counter filter with threshold total and sweep sequencer
module fws_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fws_pkg::filt_cmd_t  cmd_i,
  input  logic [7:0]          threshold_i,
  input  logic [11:0]         limit_i,
  output fws_pkg::filt_stat_t stat_o
);
  import fws_pkg::*;

  localparam logic [FIDX_W-1:0] LAST = FIDX_W'(FCOLS - 1);

  logic [CNT_W-1:0] cnt_mem  [FROWS][FCOLS];
  logic             mark_mem [FROWS][FCOLS];

  filt_state_e state_q, state_d;
  logic [FIDX_W-1:0] ptr_q, ptr_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic              pass_q, pass_d, done_q, done_d;
  logic [FROWS-1:0][FIDX_W-1:0] idx_q, idx_d;

  logic [FROWS-1:0][FIDX_W-1:0] rd_addr, wr_addr;
  logic [FROWS-1:0][CNT_W-1:0]  cnt_rd_q, wr_cnt, bumped;
  logic [FROWS-1:0]             mark_rd_q, wr_mark, cnt_we, bmp;
  logic                         mark_we, rd_use_cmd, wr_use_ptr;

  logic [CNT_W-1:0] mn;
  logic [1:0]       mr, add_n;
  logic             all_marks, below, eq3, p01, p12, p02, pass_now;
  logic [TOT_W:0]   sum;
  logic [TOT_W-1:0] total_new;

  always_comb begin
    for (int r = 0; r < FROWS; r++) begin
      rd_addr[r] = rd_use_cmd ? cmd_i.idx[r] : ptr_q;
      wr_addr[r] = wr_use_ptr ? ptr_q : idx_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < FROWS; r++) begin
      cnt_rd_q[r]  <= cnt_mem[r][rd_addr[r]];
      mark_rd_q[r] <= mark_mem[r][rd_addr[r]];
      if (cnt_we[r]) begin
        cnt_mem[r][wr_addr[r]] <= wr_cnt[r];
      end
      if (mark_we) begin
        mark_mem[r][wr_addr[r]] <= wr_mark[r];
      end
    end
  end

  // bucket choice for one insert
  always_comb begin
    mn = cnt_rd_q[0];
    mr = 2'd0;
    all_marks = &mark_rd_q;
    for (int r = 1; r < FROWS; r++) begin
      if (cnt_rd_q[r] < mn) begin
        mn = cnt_rd_q[r];
        mr = 2'(r);
      end
    end
    below = mn < threshold_i;
    pass_now = !(below && !all_marks);
    eq3 = (cnt_rd_q[0] == cnt_rd_q[1]) && (cnt_rd_q[1] == cnt_rd_q[2]);
    p01 = (cnt_rd_q[0] == cnt_rd_q[1]) && (cnt_rd_q[1] == mn);
    p12 = (cnt_rd_q[1] == cnt_rd_q[2]) && (cnt_rd_q[2] == mn);
    p02 = (cnt_rd_q[0] == cnt_rd_q[2]) && (cnt_rd_q[2] == mn);
    add_n = 2'd0;
    if (eq3) begin
      bmp = 3'b111;
      if ({1'b0, cnt_rd_q[0]} + 9'd1 == {1'b0, threshold_i}) add_n = 2'd3;
    end else if (p01) begin
      bmp = 3'b011;
      if ({1'b0, cnt_rd_q[0]} + 9'd1 == {1'b0, threshold_i}) add_n = 2'd2;
    end else if (p12) begin
      bmp = 3'b110;
      if ({1'b0, cnt_rd_q[1]} + 9'd1 == {1'b0, threshold_i}) add_n = 2'd2;
    end else if (p02) begin
      bmp = 3'b101;
      if ({1'b0, cnt_rd_q[0]} + 9'd1 == {1'b0, threshold_i}) add_n = 2'd2;
    end else begin
      bmp = 3'b000;
      bmp[mr] = 1'b1;
    end
    if (!below) add_n = 2'd0;
    for (int r = 0; r < FROWS; r++) begin
      bumped[r] = (cnt_rd_q[r] == '1) ? cnt_rd_q[r] : cnt_rd_q[r] + CNT_W'(1);
    end
    sum = (TOT_W+1)'(total_q) + (TOT_W+1)'(add_n);
    total_new = (sum > (TOT_W+1)'(TOT_MAX)) ? TOT_MAX : sum[TOT_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    total_d = total_q;
    pass_d = pass_q;
    idx_d = idx_q;
    done_d = 1'b0;
    rd_use_cmd = 1'b0;
    wr_use_ptr = 1'b1;
    cnt_we = '0;
    mark_we = 1'b0;
    wr_cnt = '0;
    wr_mark = '0;
    unique case (state_q)
      F_CLEAR: begin
        cnt_we = '1;
        mark_we = 1'b1;
        ptr_d = ptr_q + FIDX_W'(1);
        if (ptr_q == LAST) begin
          ptr_d = '0;
          state_d = F_IDLE;
        end
      end
      F_IDLE: begin
        rd_use_cmd = 1'b1;
        if (cmd_i.start) begin
          idx_d = cmd_i.idx;
          state_d = F_UPD;
        end
      end
      F_UPD: begin
        wr_use_ptr = 1'b0;
        for (int r = 0; r < FROWS; r++) begin
          cnt_we[r] = below && bmp[r];
        end
        wr_cnt = bumped;
        pass_d = pass_now;
        total_d = total_new;
        if (total_new >= limit_i) begin
          ptr_d = '0;
          state_d = F_SWEEP_RD;
        end else begin
          done_d = 1'b1;
          state_d = F_IDLE;
        end
      end
      F_SWEEP_RD: begin
        state_d = F_SWEEP_WR;
      end
      F_SWEEP_WR: begin
        cnt_we = '1;
        mark_we = 1'b1;
        for (int r = 0; r < FROWS; r++) begin
          wr_mark[r] = cnt_rd_q[r] >= threshold_i;
        end
        if (ptr_q == LAST) begin
          ptr_d = '0;
          total_d = '0;
          done_d = 1'b1;
          state_d = F_IDLE;
        end else begin
          ptr_d = ptr_q + FIDX_W'(1);
          state_d = F_SWEEP_RD;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_CLEAR;
      ptr_q <= '0;
      total_q <= '0;
      pass_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
      total_q <= total_d;
      pass_q <= pass_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign stat_o.ready = (state_q == F_IDLE);
  assign stat_o.done  = done_q;
  assign stat_o.pass  = pass_q;

endmodule

// ===== sv/fws_record.sv =====
// waving record table with a slot-by-slot compare unit
module fws_record (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fws_pkg::rec_cmd_t  cmd_i,
  output fws_pkg::rec_stat_t stat_o
);
  import fws_pkg::*;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic signed [SUM_W-1:0] W_HI =
    {{(SUM_W-WAV_W+1){1'b0}}, {(WAV_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] W_LO =
    {{(SUM_W-WAV_W+1){1'b1}}, {(WAV_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1);

  logic [SLOTS*KEY_W-1:0]      key_mem [ROWS];
  logic [SLOTS*COUNT_BITS-1:0] cnt_mem [ROWS];
  logic [SLOTS*ST_W-1:0]       st_mem  [ROWS];
  logic [WAV_W-1:0]            wav_mem [ROWS];

  logic [SLOTS*KEY_W-1:0]      key_rd_q, key_wr;
  logic [SLOTS*COUNT_BITS-1:0] cnt_rd_q, cnt_wr;
  logic [SLOTS*ST_W-1:0]       st_rd_q, st_wr;
  logic [WAV_W-1:0]            wav_rd_q, wav_wr;
  logic we_key, we_cnt, we_st, we_wav;
  logic [ROW_W-1:0] rd_row, wr_row;

  rec_state_e state_q, state_d;
  slot_hit_e  hit_q, hit_d;
  logic [ROW_W-1:0]  ptr_q, ptr_d, row_q, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d, mi_q, mi_d, sel_q, sel_d;
  logic [COUNT_BITS-1:0] min_q, min_d, count_q, count_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic query_q, query_d, sign_q, sign_d, done_q, done_d, found_q, found_d;

  logic [KEY_W-1:0]      cur_key;
  logic [COUNT_BITS-1:0] cur_cnt, sel_cnt, cnt_inc;
  logic [ST_W-1:0]       cur_st, sel_st;
  logic match;
  logic signed [SUM_W-1:0] w_ext, cnt_ext, prod, delta, w_new;
  logic replace;

  assign rd_row = (state_q == R_IDLE) ? cmd_i.row : row_q;
  assign wr_row = (state_q == R_CLEAR) ? ptr_q : row_q;

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[rd_row];
    cnt_rd_q <= cnt_mem[rd_row];
    st_rd_q  <= st_mem[rd_row];
    wav_rd_q <= wav_mem[rd_row];
    if (we_key) key_mem[wr_row] <= key_wr;
    if (we_cnt) cnt_mem[wr_row] <= cnt_wr;
    if (we_st)  st_mem[wr_row]  <= st_wr;
    if (we_wav) wav_mem[wr_row] <= wav_wr;
  end

  // compare unit on the slot under the scan pointer
  always_comb begin
    cur_key = key_rd_q[slot_q*KEY_W +: KEY_W];
    cur_cnt = cnt_rd_q[slot_q*COUNT_BITS +: COUNT_BITS];
    cur_st  = st_rd_q[slot_q*ST_W +: ST_W];
    match   = cur_st[ST_VALID] && (cur_key == key_q);
  end

  // waving counter decision for a full row
  always_comb begin
    sel_cnt = cnt_rd_q[sel_q*COUNT_BITS +: COUNT_BITS];
    sel_st  = st_rd_q[sel_q*ST_W +: ST_W];
    cnt_inc = (sel_cnt == '1) ? sel_cnt : sel_cnt + COUNT_BITS'(1);
    w_ext   = SUM_W'(signed'(wav_rd_q));
    cnt_ext = SUM_W'(sel_cnt);
    prod    = sign_q ? w_ext : -w_ext;
    replace = prod >= cnt_ext;
    if (sel_st[ST_EXACT]) begin
      delta = sel_st[ST_SIGN] ? cnt_ext : -cnt_ext;
    end else begin
      delta = sel_st[ST_SIGN] ? ONE : -ONE;
    end
    if (replace) begin
      w_new = w_ext + delta;
    end else begin
      w_new = sign_q ? w_ext + ONE : w_ext - ONE;
    end
    if (state_q == R_CLEAR) begin
      wav_wr = '0;
    end else if (w_new > W_HI) begin
      wav_wr = W_HI[WAV_W-1:0];
    end else if (w_new < W_LO) begin
      wav_wr = W_LO[WAV_W-1:0];
    end else begin
      wav_wr = w_new[WAV_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    hit_d = hit_q;
    ptr_d = ptr_q;
    row_d = row_q;
    slot_d = slot_q;
    mi_d = mi_q;
    sel_d = sel_q;
    min_d = min_q;
    key_d = key_q;
    query_d = query_q;
    sign_d = sign_q;
    found_d = found_q;
    count_d = count_q;
    done_d = 1'b0;
    we_key = 1'b0;
    we_cnt = 1'b0;
    we_st = 1'b0;
    we_wav = 1'b0;
    key_wr = key_rd_q;
    cnt_wr = cnt_rd_q;
    st_wr = st_rd_q;
    unique case (state_q)
      R_CLEAR: begin
        st_wr = '0;
        we_st = 1'b1;
        we_wav = 1'b1;
        ptr_d = ptr_q + ROW_W'(1);
        if (ptr_q == LAST_ROW) state_d = R_IDLE;
      end
      R_IDLE: begin
        if (cmd_i.start) begin
          row_d = cmd_i.row;
          key_d = cmd_i.key;
          query_d = cmd_i.query;
          sign_d = cmd_i.sign;
          slot_d = '0;
          mi_d = '0;
          min_d = '1;
          state_d = R_SCAN;
        end
      end
      R_SCAN: begin
        if (cur_cnt < min_q) begin
          min_d = cur_cnt;
          mi_d = slot_q;
        end
        if (match) begin
          hit_d = HIT_MATCH;
          sel_d = slot_q;
          state_d = R_WRITE;
        end else if (!cur_st[ST_VALID] && !query_q) begin
          hit_d = HIT_EMPTY;
          sel_d = slot_q;
          state_d = R_WRITE;
        end else if (slot_q == LAST_SLOT) begin
          hit_d = query_q ? HIT_NONE : HIT_FULL;
          sel_d = (cur_cnt < min_q) ? slot_q : mi_q;
          state_d = R_WRITE;
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
      R_WRITE: begin
        found_d = query_q && (hit_q == HIT_MATCH);
        count_d = found_d ? sel_cnt : '0;
        done_d = 1'b1;
        state_d = R_IDLE;
        if (!query_q) begin
          unique case (hit_q)
            HIT_MATCH: begin
              cnt_wr[sel_q*COUNT_BITS +: COUNT_BITS] = cnt_inc;
              we_cnt = 1'b1;
            end
            HIT_EMPTY: begin
              key_wr[sel_q*KEY_W +: KEY_W] = key_q;
              cnt_wr[sel_q*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(1);
              st_wr[sel_q*ST_W +: ST_W] = {sign_q, 1'b1, 1'b1};
              we_key = 1'b1;
              we_cnt = 1'b1;
              we_st = 1'b1;
            end
            HIT_FULL: begin
              we_wav = 1'b1;
              key_wr[sel_q*KEY_W +: KEY_W] = key_q;
              cnt_wr[sel_q*COUNT_BITS +: COUNT_BITS] = cnt_inc;
              st_wr[sel_q*ST_W +: ST_W] = {sign_q, 1'b0, 1'b1};
              we_key = replace;
              we_cnt = replace;
              we_st = replace;
            end
            default: ;
          endcase
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_CLEAR;
      ptr_q <= '0;
      done_q <= 1'b0;
      found_q <= 1'b0;
      hit_q <= HIT_NONE;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
      done_q <= done_d;
      found_q <= found_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    slot_q <= slot_d;
    mi_q <= mi_d;
    sel_q <= sel_d;
    min_q <= min_d;
    key_q <= key_d;
    query_q <= query_d;
    sign_q <= sign_d;
    count_q <= count_d;
  end

  assign stat_o.ready = (state_q == R_IDLE);
  assign stat_o.done  = done_q;
  assign stat_o.found = found_q;
  assign stat_o.count = count_q;

endmodule
